// ===== src/rlpg_pkg.sv =====
// ============================================================================
// rlpg_pkg
// Shared types, constants and the speed table of the RGB pattern generator.
// ============================================================================
package rlpg_pkg;

    localparam int MODE_COUNT         = 14;
    localparam int MODE_W             = 4;
    localparam int STEP_W             = 8;
    localparam int TIMER_W            = 13;
    localparam int DUTY_W             = 7;
    localparam int LEVEL_W            = 4;
    localparam int MS_W               = 8;
    localparam int DEF_SPEED_LEVELS   = 13;
    localparam int TABLE_LEN          = 13;
    localparam logic [LEVEL_W-1:0] RESET_LEVEL = 4'd3;
    localparam logic [DUTY_W-1:0]  DUTY_FULL   = 7'd100;

    // Pattern modes, numbered in display order
    typedef enum logic [MODE_W-1:0] {
        MODE_OFF      = 4'd0,
        MODE_RED      = 4'd1,
        MODE_GREEN    = 4'd2,
        MODE_BLUE     = 4'd3,
        MODE_YELLOW   = 4'd4,
        MODE_PURPLE   = 4'd5,
        MODE_CYAN     = 4'd6,
        MODE_WHITE    = 4'd7,
        MODE_RED_GRN  = 4'd8,
        MODE_BLU_GRN  = 4'd9,
        MODE_RED_BLU  = 4'd10,
        MODE_CYCLE7   = 4'd11,
        MODE_RAMP_RGB = 4'd12,
        MODE_RAMP7    = 4'd13
    } mode_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_KEY  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KEY_NONE   = 2'd0,
        KEY_NEXT   = 2'd1,
        KEY_FASTER = 2'd2,
        KEY_SLOWER = 2'd3
    } key_t;

    // Colour decoder output
    typedef struct packed {
        logic              update;
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
    } color_t;

    // One result item
    typedef struct packed {
        color_t            color;
        logic              display;
        logic [MODE_W-1:0] mode;
    } result_t;

    // Blink interval in ms per speed level; saturates at the last entry
    function automatic logic [TIMER_W-1:0] interval_ms(input logic [LEVEL_W-1:0] lvl);
        logic [TIMER_W-1:0] iv;
        case (lvl)
            4'd0:    iv = 13'd50;
            4'd1:    iv = 13'd100;
            4'd2:    iv = 13'd200;
            4'd3:    iv = 13'd300;
            4'd4:    iv = 13'd400;
            4'd5:    iv = 13'd500;
            4'd6:    iv = 13'd600;
            4'd7:    iv = 13'd800;
            4'd8:    iv = 13'd1000;
            4'd9:    iv = 13'd1500;
            4'd10:   iv = 13'd2000;
            4'd11:   iv = 13'd3000;
            default: iv = 13'd5000;
        endcase
        return iv;
    endfunction

endpackage

// ===== src/rlpg_color.sv =====
// ============================================================================
// rlpg_color
// Decodes mode and step into a duty triple and the following step value.
// ============================================================================
module rlpg_color (
    input  logic [rlpg_pkg::MODE_W-1:0] mode,
    input  logic [rlpg_pkg::STEP_W-1:0] step,
    output rlpg_pkg::color_t            color,
    output logic [rlpg_pkg::STEP_W-1:0] step_next
);

    localparam logic [rlpg_pkg::STEP_W-1:0] SEG_LEN   = 8'd20;
    localparam logic [rlpg_pkg::STEP_W-1:0] RAMP_TOP  = 8'd60;
    localparam logic [8:0]                  RAMP7_LEN = 9'd140;

    logic [rlpg_pkg::DUTY_W-1:0] on_lvl;
    logic [rlpg_pkg::DUTY_W-1:0] alt_lvl;
    logic [rlpg_pkg::STEP_W-1:0] toggle;
    logic [rlpg_pkg::STEP_W-1:0] s_inc;
    logic [rlpg_pkg::STEP_W-1:0] s_g;
    logic [rlpg_pkg::STEP_W-1:0] s_b;
    logic [9:0]                  ramp_r;
    logic [9:0]                  ramp_g;
    logic [9:0]                  ramp_b;
    logic [8:0]                  s7_inc;
    logic [15:0]                 q_prod;
    logic [3:0]                  seg_q;
    logic [3:0]                  seg_sel;
    logic [4:0]                  seg_rem;
    logic [7:0]                  seg_lvl;

    // Blink phases and step toggle
    assign on_lvl  = (step == '0) ? rlpg_pkg::DUTY_FULL : '0;
    assign alt_lvl = (step != '0) ? rlpg_pkg::DUTY_FULL : '0;
    assign toggle  = (step == '0) ? 8'd1 : 8'd0;

    // RGB ramp: x5 of the position within each 20-step segment
    assign s_inc  = step + 8'd1;
    assign s_g    = s_inc - SEG_LEN;
    assign s_b    = s_inc - 8'd40;
    assign ramp_r = (10'(s_inc) << 2) + 10'(s_inc);
    assign ramp_g = (10'(s_g) << 2) + 10'(s_g);
    assign ramp_b = (10'(s_b) << 2) + 10'(s_b);

    // Seven-colour ramp: step / 20 by reciprocal (exact for 8-bit steps)
    assign q_prod  = 16'(step) * 16'd205;
    assign seg_q   = q_prod[15:12];
    assign seg_rem = 5'(step - 8'(seg_q) * SEG_LEN);
    assign seg_sel = seg_q + 4'd1;
    assign seg_lvl = (8'(seg_rem) + 8'd1) * 8'd5;
    assign s7_inc  = 9'(step) + 9'd1;

    // Mode decode
    always_comb
    begin
        color     = '0;
        step_next = step;
        case (mode)
            rlpg_pkg::MODE_OFF:
            begin
                color.update = 1'b1;
            end
            rlpg_pkg::MODE_RED:
            begin
                color.update = 1'b1;
                color.red    = on_lvl;
                step_next    = toggle;
            end
            rlpg_pkg::MODE_GREEN:
            begin
                color.update = 1'b1;
                color.green  = on_lvl;
                step_next    = toggle;
            end
            rlpg_pkg::MODE_BLUE:
            begin
                color.update = 1'b1;
                color.blue   = on_lvl;
                step_next    = toggle;
            end
            rlpg_pkg::MODE_YELLOW:
            begin
                color.update = 1'b1;
                color.red    = on_lvl;
                color.green  = on_lvl;
                step_next    = toggle;
            end
            rlpg_pkg::MODE_PURPLE:
            begin
                color.update = 1'b1;
                color.red    = on_lvl;
                color.blue   = on_lvl;
                step_next    = toggle;
            end
            rlpg_pkg::MODE_CYAN:
            begin
                color.update = 1'b1;
                color.green  = on_lvl;
                color.blue   = on_lvl;
                step_next    = toggle;
            end
            rlpg_pkg::MODE_WHITE:
            begin
                color.update = 1'b1;
                color.red    = on_lvl;
                color.green  = on_lvl;
                color.blue   = on_lvl;
                step_next    = toggle;
            end
            rlpg_pkg::MODE_RED_GRN:
            begin
                color.update = 1'b1;
                color.red    = on_lvl;
                color.green  = alt_lvl;
                step_next    = toggle;
            end
            rlpg_pkg::MODE_BLU_GRN:
            begin
                color.update = 1'b1;
                color.green  = alt_lvl;
                color.blue   = on_lvl;
                step_next    = toggle;
            end
            rlpg_pkg::MODE_RED_BLU:
            begin
                color.update = 1'b1;
                color.red    = on_lvl;
                color.blue   = alt_lvl;
                step_next    = toggle;
            end
            rlpg_pkg::MODE_CYCLE7:
            begin
                color.update = 1'b1;
                color.red    = s_inc[0] ? rlpg_pkg::DUTY_FULL : '0;
                color.green  = s_inc[1] ? rlpg_pkg::DUTY_FULL : '0;
                color.blue   = s_inc[2] ? rlpg_pkg::DUTY_FULL : '0;
                step_next    = (s_inc >= 8'd7) ? '0 : s_inc;
            end
            rlpg_pkg::MODE_RAMP_RGB:
            begin
                color.update = 1'b1;
                color.red    = (s_inc <= SEG_LEN) ? ramp_r[6:0] : '0;
                color.green  = (s_inc > SEG_LEN && s_inc <= 8'd40) ? ramp_g[6:0] : '0;
                color.blue   = (s_inc > 8'd40 && s_inc <= RAMP_TOP) ? ramp_b[6:0] : '0;
                step_next    = (s_inc >= RAMP_TOP) ? '0 : s_inc;
            end
            rlpg_pkg::MODE_RAMP7:
            begin
                color.update = 1'b1;
                color.red    = seg_sel[0] ? seg_lvl[6:0] : '0;
                color.green  = seg_sel[1] ? seg_lvl[6:0] : '0;
                color.blue   = seg_sel[2] ? seg_lvl[6:0] : '0;
                step_next    = (s7_inc >= RAMP7_LEN) ? '0 : s7_inc[7:0];
            end
            default:
            begin
                color = '0;
            end
        endcase
    end

endmodule

// ===== src/rlpg_state.sv =====
// ============================================================================
// rlpg_state
// Pattern state registers, tick timer and key handling for one item.
// ============================================================================
module rlpg_state #(
    parameter int SPEED_LEVELS = rlpg_pkg::DEF_SPEED_LEVELS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        operation,
    input  logic [rlpg_pkg::MS_W-1:0]   elapsed_ms,
    input  logic [1:0]                  key_code,
    output rlpg_pkg::result_t           result
);

    localparam logic [rlpg_pkg::LEVEL_W:0] LEVELS = (rlpg_pkg::LEVEL_W + 1)'(SPEED_LEVELS);

    logic [rlpg_pkg::MODE_W-1:0]  mode_reg,  mode_next;
    logic [rlpg_pkg::STEP_W-1:0]  step_reg,  step_next;
    logic [rlpg_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic [rlpg_pkg::LEVEL_W-1:0] level_reg, level_next;

    rlpg_pkg::color_t             dec_color;
    logic [rlpg_pkg::STEP_W-1:0]  dec_step;
    logic [rlpg_pkg::TIMER_W:0]   timer_sum;
    logic [rlpg_pkg::TIMER_W-1:0] interval;
    logic                         due;
    rlpg_pkg::key_t               key;

    rlpg_color u_color (
        .mode      (mode_reg),
        .step      (step_reg),
        .color     (dec_color),
        .step_next (dec_step)
    );

    assign key       = rlpg_pkg::key_t'(key_code);
    assign due       = (timer_reg == '0);
    assign interval  = rlpg_pkg::interval_ms(level_reg);
    assign timer_sum = (rlpg_pkg::TIMER_W + 1)'(timer_reg) + (rlpg_pkg::TIMER_W + 1)'(elapsed_ms);

    // Next state and result for the item in the input register
    always_comb
    begin
        mode_next      = mode_reg;
        step_next      = step_reg;
        timer_next     = timer_reg;
        level_next     = level_reg;
        result         = '0;
        if (rlpg_pkg::op_t'(operation) == rlpg_pkg::OP_TICK)
        begin
            if (due)
            begin
                result.color = dec_color;
                step_next    = dec_step;
            end
            timer_next = (timer_sum >= (rlpg_pkg::TIMER_W + 1)'(interval)) ?
                         '0 : timer_sum[rlpg_pkg::TIMER_W-1:0];
        end
        else
        begin
            case (key)
                rlpg_pkg::KEY_NEXT:
                begin
                    mode_next      = (mode_reg >= 4'(rlpg_pkg::MODE_COUNT - 1)) ?
                                     '0 : mode_reg + 4'd1;
                    result.display = 1'b1;
                end
                rlpg_pkg::KEY_FASTER:
                begin
                    if (level_reg != '0)
                    begin
                        level_next = level_reg - 4'd1;
                    end
                end
                rlpg_pkg::KEY_SLOWER:
                begin
                    if ((5'(level_reg) + 5'd1) < LEVELS)
                    begin
                        level_next = level_reg + 4'd1;
                    end
                end
                default:
                begin
                    level_next = level_reg;
                end
            endcase
            step_next  = '0;
            timer_next = '0;
        end
        result.mode = mode_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= rlpg_pkg::MODE_OFF;
            step_reg  <= '0;
            timer_reg <= '0;
            level_reg <= rlpg_pkg::RESET_LEVEL;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            step_reg  <= step_next;
            timer_reg <= timer_next;
            level_reg <= level_next;
        end
    end

    // Checks
    mode_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg < 4'(rlpg_pkg::MODE_COUNT))
        else $error("pattern mode out of range");

    timer_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        timer_reg < 13'd5000)
        else $error("interval timer reached the longest interval");

    key_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        advance && operation |=> timer_reg == '0 && step_reg == '0)
        else $error("key item did not clear step and timer");

endmodule

// ===== src/rgb_light_pattern_generator_top.sv =====
// ============================================================================
// rgb_light_pattern_generator_top
// Stage-light RGB pattern generator: tick and key items in, one result out.
// ============================================================================
// Path: the input register takes an accepted item; the state update then
//   writes the result register, held while that is full and out_ready is low.
// Throughput: one item per cycle while out_ready keeps the result register free;
//   the state update is a single pass of small compares and adds between the two registers.
// Reset: rst_n clears both registers' valid flags, mode to off, step and
//   timer to zero and the speed level to 3.
module rgb_light_pattern_generator_top #(
    parameter int SPEED_LEVELS = rlpg_pkg::DEF_SPEED_LEVELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [rlpg_pkg::MS_W-1:0]     elapsed_ms,
    input  logic [1:0]                    key_code,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          color_update,
    output logic [rlpg_pkg::DUTY_W-1:0]   red_duty,
    output logic [rlpg_pkg::DUTY_W-1:0]   green_duty,
    output logic [rlpg_pkg::DUTY_W-1:0]   blue_duty,
    output logic                          display_update,
    output logic [rlpg_pkg::MODE_W-1:0]   shown_mode
);

    logic                        in_vld_reg, in_vld_next;
    logic                        op_reg;
    logic [rlpg_pkg::MS_W-1:0]   ms_reg;
    logic [1:0]                  key_reg;
    logic                        out_vld_reg, out_vld_next;
    rlpg_pkg::result_t           res_reg;
    rlpg_pkg::result_t           res_next;
    logic                        advance;
    logic                        in_take;

    // Handshake
    assign advance     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready    = !in_vld_reg || advance;
    assign in_take     = in_valid && in_ready;
    assign in_vld_next = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);

    rlpg_state #(
        .SPEED_LEVELS (SPEED_LEVELS)
    ) u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .operation  (op_reg),
        .elapsed_ms (ms_reg),
        .key_code   (key_reg),
        .result     (res_next)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= operation;
            ms_reg  <= elapsed_ms;
            key_reg <= key_code;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_vld_reg;
    assign color_update   = res_reg.color.update;
    assign red_duty       = res_reg.color.red;
    assign green_duty     = res_reg.color.green;
    assign blue_duty      = res_reg.color.blue;
    assign display_update = res_reg.display;
    assign shown_mode     = res_reg.mode;

    // Checks
    empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> in_ready)
        else $error("input stalled while result register empty");

    key_has_no_color: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && display_update |-> !color_update)
        else $error("mode display and colour update in one item");

    idle_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !color_update |->
            red_duty == '0 && green_duty == '0 && blue_duty == '0)
        else $error("duty driven without colour update");

    duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> red_duty <= rlpg_pkg::DUTY_FULL &&
            green_duty <= rlpg_pkg::DUTY_FULL && blue_duty <= rlpg_pkg::DUTY_FULL)
        else $error("duty above full scale");

endmodule
